// ----- rtl/plcr_pkg.sv -----
// Shared types and constants for the piecewise linear calibration ratio block.
// No dependencies; every other file in rtl/ imports this package.
package plcr_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned SEG_W  = 6;
  localparam int unsigned PROD_W = 64;
  localparam int unsigned STEP_W = 7;

  localparam logic [STEP_W-1:0] DIV1_STEPS = 7'd64;
  localparam logic [STEP_W-1:0] DIV2_STEPS = 7'd48;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_LOAD  = 2'd1,
    OP_EVAL  = 2'd2,
    OP_NONE  = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_SHORT = 2'd2,
    ST_ZDIV  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    RD_FIRST,
    RD_LAST,
    RD_ONE,
    RD_HI_NEXT,
    RD_HI_M1,
    RD_HI
  } rd_sel_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_CHK_FIRST,
    S_CHK_LAST,
    S_SCAN,
    S_RD_LO,
    S_RD_HI,
    S_WAIT_HI,
    S_DIFF,
    S_MUL,
    S_DIV1,
    S_DIV1_WAIT,
    S_CHK_NORM,
    S_DIV2_WAIT,
    S_RESULT
  } state_e;

  typedef struct packed {
    logic [1:0]               opcode;
    logic signed [DATA_W-1:0] x_value;
    logic signed [DATA_W-1:0] y_value;
  } plcr_in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] ratio;
    logic [1:0]               status;
    logic [SEG_W-1:0]         segment_index;
  } plcr_out_t;

  typedef struct packed {
    logic    capture;
    logic    clear_cnt;
    logic    write_pt;
    logic    rd_en;
    rd_sel_e rd_sel;
    logic    hi_one;
    logic    hi_last;
    logic    hi_inc;
    logic    lat_lo;
    logic    lat_hi;
    logic    diff;
    logic    mul;
    logic    div1_start;
    logic    norm;
    logic    div2_start;
    logic    fin;
    status_e fin_status;
    logic    fin_seg;
    logic    fin_ratio;
    logic    emit;
  } plcr_cmd_t;

  typedef struct packed {
    opcode_e op;
    logic    full;
    logic    short_tab;
    logic    x_le;
    logic    x_ge;
    logic    x_gt;
    logic    hi_lt_last;
    logic    dx_zero;
    logic    uq_big;
    logic    ynorm_zero;
    logic    div_done;
    logic    out_free;
  } plcr_sts_t;

endpackage

// ----- rtl/plcr_div.sv -----
// Restoring unsigned divider, one quotient bit per cycle, step count per start.
// Depends on plcr_pkg for widths.
module plcr_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [plcr_pkg::PROD_W-1:0]   dividend_i,
  input  logic [plcr_pkg::PROD_W-1:0]   divisor_i,
  input  logic [plcr_pkg::STEP_W-1:0]   steps_i,
  output logic [plcr_pkg::PROD_W-1:0]   quotient_o,
  output logic                          busy_o
);
  import plcr_pkg::*;

  logic [PROD_W-1:0] rem_q, rem_d, quo_q, quo_d, dsr_q;
  logic [PROD_W:0]   trial;
  logic [STEP_W-1:0] cnt_q, cnt_d;
  logic              busy_q, busy_d, fit;

  always_comb begin
    trial = {rem_q, quo_q[PROD_W-1]};
    fit   = trial >= {1'b0, dsr_q};
    rem_d = rem_q;
    quo_d = quo_q;
    cnt_d = cnt_q;
    busy_d = busy_q;
    if (start_i) begin
      rem_d  = '0;
      quo_d  = dividend_i;
      cnt_d  = steps_i;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d  = fit ? PROD_W'(trial - {1'b0, dsr_q}) : trial[PROD_W-1:0];
      quo_d  = {quo_q[PROD_W-2:0], fit};
      cnt_d  = cnt_q - STEP_W'(1);
      busy_d = (cnt_q != STEP_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (start_i) begin
      dsr_q <= divisor_i;
    end
  end

  assign quotient_o = quo_q;
  assign busy_o     = busy_q;

endmodule

// ----- rtl/plcr_dp.sv -----
// Datapath: point memory, search index, interpolation arithmetic, result registers.
// Depends on plcr_pkg and plcr_div; driven by plcr_ctrl commands.
module plcr_dp #(
  parameter int unsigned TABLE_DEPTH = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  plcr_pkg::plcr_in_t  in_data_i,
  input  logic                out_ready_i,
  input  plcr_pkg::plcr_cmd_t cmd_i,
  output plcr_pkg::plcr_sts_t sts_o,
  output logic                out_valid_o,
  output plcr_pkg::plcr_out_t out_data_o
);
  import plcr_pkg::*;

  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

  function automatic logic [DATA_W-1:0] mag33(input logic [DATA_W:0] v);
    logic [DATA_W:0] n;
    n = v[DATA_W] ? (~v + (DATA_W+1)'(1)) : v;
    return n[DATA_W-1:0];
  endfunction

  logic [1:0]               op_q;
  logic signed [DATA_W-1:0] xq_q, yq_q, rd_x;
  logic [CW-1:0]            cnt_q, cnt_d;
  logic [AW-1:0]            hi_q, hi_d, last, rd_addr;
  logic [2*DATA_W-1:0]      mem [TABLE_DEPTH];
  logic [2*DATA_W-1:0]      rd_q;
  logic [DATA_W-1:0]        x0_q, x1_q, y0_q, y1_q;
  logic [DATA_W:0]          dx, dy, dq;
  logic [DATA_W-1:0]        dxm_q, dym_q, dqm_q, ymag;
  logic                     neg_q, neg2_q;
  logic [PROD_W-1:0]        prod_q, ynorm_q, ynorm_mag, q_s, div_quo;
  logic [PROD_W-1:0]        div_dividend, div_divisor;
  logic [STEP_W-1:0]        div_steps;
  logic                     div_start, div_busy;
  logic [DATA_W-1:0]        sat;
  plcr_out_t                res_q, out_q;
  logic                     out_valid_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q <= in_data_i.opcode;
      xq_q <= in_data_i.x_value;
      yq_q <= in_data_i.y_value;
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.clear_cnt) begin
      cnt_d = '0;
    end else if (cmd_i.write_pt) begin
      cnt_d = cnt_q + CW'(1);
    end
  end

  assign last = AW'(cnt_q - CW'(1));

  always_comb begin
    hi_d = hi_q;
    if (cmd_i.hi_one) begin
      hi_d = AW'(1);
    end else if (cmd_i.hi_last) begin
      hi_d = last;
    end else if (cmd_i.hi_inc) begin
      hi_d = hi_q + AW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      hi_q  <= '0;
    end else begin
      cnt_q <= cnt_d;
      hi_q  <= hi_d;
    end
  end

  always_comb begin
    case (cmd_i.rd_sel)
      RD_FIRST:   rd_addr = '0;
      RD_LAST:    rd_addr = last;
      RD_ONE:     rd_addr = AW'(1);
      RD_HI_NEXT: rd_addr = hi_q + AW'(1);
      RD_HI_M1:   rd_addr = hi_q - AW'(1);
      RD_HI:      rd_addr = hi_q;
      default:    rd_addr = hi_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.write_pt) begin
      mem[cnt_q[AW-1:0]] <= {xq_q, yq_q};
    end
    if (cmd_i.rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  assign rd_x = signed'(rd_q[2*DATA_W-1:DATA_W]);

  assign dx = {x1_q[DATA_W-1], x1_q} - {x0_q[DATA_W-1], x0_q};
  assign dy = {y1_q[DATA_W-1], y1_q} - {y0_q[DATA_W-1], y0_q};
  assign dq = {xq_q[DATA_W-1], xq_q} - {x0_q[DATA_W-1], x0_q};
  assign ymag = mag33({yq_q[DATA_W-1], yq_q});

  assign q_s       = neg_q ? (~div_quo + PROD_W'(1)) : div_quo;
  assign ynorm_mag = ynorm_q[PROD_W-1] ? (~ynorm_q + PROD_W'(1)) : ynorm_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.lat_lo) begin
      x0_q <= rd_q[2*DATA_W-1:DATA_W];
      y0_q <= rd_q[DATA_W-1:0];
    end
    if (cmd_i.lat_hi) begin
      x1_q <= rd_q[2*DATA_W-1:DATA_W];
      y1_q <= rd_q[DATA_W-1:0];
    end
    if (cmd_i.diff) begin
      dxm_q <= mag33(dx);
      dym_q <= mag33(dy);
      dqm_q <= mag33(dq);
      neg_q <= dx[DATA_W] ^ dy[DATA_W] ^ dq[DATA_W];
    end
    if (cmd_i.mul) begin
      prod_q <= PROD_W'(dym_q) * PROD_W'(dqm_q);
    end
    if (cmd_i.norm) begin
      ynorm_q <= {{(PROD_W-DATA_W){y0_q[DATA_W-1]}}, y0_q} + q_s;
    end
    if (cmd_i.div2_start) begin
      neg2_q <= yq_q[DATA_W-1] ^ ynorm_q[PROD_W-1];
    end
  end

  assign div_start    = cmd_i.div1_start | cmd_i.div2_start;
  assign div_dividend = cmd_i.div2_start ? {ymag, {DATA_W{1'b0}}} : prod_q;
  assign div_divisor  = cmd_i.div2_start ? ynorm_mag : {{(PROD_W-DATA_W){1'b0}}, dxm_q};
  assign div_steps    = cmd_i.div2_start ? DIV2_STEPS : DIV1_STEPS;

  plcr_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .steps_i    (div_steps),
    .quotient_o (div_quo),
    .busy_o     (div_busy)
  );

  always_comb begin
    if (!neg2_q) begin
      sat = (div_quo > PROD_W'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : div_quo[DATA_W-1:0];
    end else begin
      sat = (div_quo > PROD_W'(32'h8000_0000)) ? 32'h8000_0000
                                               : (~div_quo[DATA_W-1:0] + 32'd1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.fin) begin
      res_q.status        <= cmd_i.fin_status;
      res_q.segment_index <= cmd_i.fin_seg ? SEG_W'(hi_q) : '0;
      res_q.ratio         <= cmd_i.fin_ratio ? signed'(sat) : '0;
    end
    if (cmd_i.emit) begin
      out_q <= res_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign sts_o.op         = opcode_e'(op_q);
  assign sts_o.full       = cnt_q >= CW'(TABLE_DEPTH);
  assign sts_o.short_tab  = cnt_q < CW'(2);
  assign sts_o.x_le       = xq_q <= rd_x;
  assign sts_o.x_ge       = xq_q >= rd_x;
  assign sts_o.x_gt       = xq_q > rd_x;
  assign sts_o.hi_lt_last = hi_q < last;
  assign sts_o.dx_zero    = x0_q == x1_q;
  assign sts_o.uq_big     = |div_quo[PROD_W-1:PROD_W-2];
  assign sts_o.ynorm_zero = ynorm_q == '0;
  assign sts_o.div_done   = !div_busy;
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ----- rtl/plcr_ctrl.sv -----
// Controller state machine: sequences table access, search and both divisions.
// Depends on plcr_pkg; talks to plcr_dp through command and status structs.
module plcr_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  plcr_pkg::plcr_sts_t sts_i,
  output plcr_pkg::plcr_cmd_t cmd_o
);
  import plcr_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_DISPATCH;
      end
      S_DISPATCH: begin
        if (sts_i.op == OP_EVAL && !sts_i.short_tab) state_d = S_CHK_FIRST;
        else state_d = S_RESULT;
      end
      S_CHK_FIRST: state_d = sts_i.x_le ? S_RD_LO : S_CHK_LAST;
      S_CHK_LAST:  state_d = sts_i.x_ge ? S_RD_LO : S_SCAN;
      S_SCAN: begin
        if (!(sts_i.hi_lt_last && sts_i.x_gt)) state_d = S_RD_LO;
      end
      S_RD_LO:   state_d = S_RD_HI;
      S_RD_HI:   state_d = S_WAIT_HI;
      S_WAIT_HI: state_d = S_DIFF;
      S_DIFF:    state_d = sts_i.dx_zero ? S_RESULT : S_MUL;
      S_MUL:     state_d = S_DIV1;
      S_DIV1:    state_d = S_DIV1_WAIT;
      S_DIV1_WAIT: begin
        if (sts_i.div_done) state_d = sts_i.uq_big ? S_RESULT : S_CHK_NORM;
      end
      S_CHK_NORM: state_d = sts_i.ynorm_zero ? S_RESULT : S_DIV2_WAIT;
      S_DIV2_WAIT: begin
        if (sts_i.div_done) state_d = S_RESULT;
      end
      S_RESULT: begin
        if (sts_i.out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      S_DISPATCH: begin
        cmd_o.fin = 1'b1;
        case (sts_i.op)
          OP_CLEAR: cmd_o.clear_cnt = 1'b1;
          OP_LOAD: begin
            if (sts_i.full) cmd_o.fin_status = ST_FULL;
            else cmd_o.write_pt = 1'b1;
          end
          OP_EVAL: begin
            if (sts_i.short_tab) begin
              cmd_o.fin_status = ST_SHORT;
            end else begin
              cmd_o.fin    = 1'b0;
              cmd_o.rd_en  = 1'b1;
              cmd_o.rd_sel = RD_FIRST;
            end
          end
          default: cmd_o.fin_status = ST_OK;
        endcase
      end
      S_CHK_FIRST: begin
        if (sts_i.x_le) begin
          cmd_o.hi_one = 1'b1;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RD_LAST;
        end
      end
      S_CHK_LAST: begin
        if (sts_i.x_ge) begin
          cmd_o.hi_last = 1'b1;
        end else begin
          cmd_o.hi_one = 1'b1;
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RD_ONE;
        end
      end
      S_SCAN: begin
        if (sts_i.hi_lt_last && sts_i.x_gt) begin
          cmd_o.hi_inc = 1'b1;
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RD_HI_NEXT;
        end
      end
      S_RD_LO: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = RD_HI_M1;
      end
      S_RD_HI: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = RD_HI;
        cmd_o.lat_lo = 1'b1;
      end
      S_WAIT_HI: cmd_o.lat_hi = 1'b1;
      S_DIFF: begin
        if (sts_i.dx_zero) begin
          cmd_o.fin        = 1'b1;
          cmd_o.fin_status = ST_ZDIV;
          cmd_o.fin_seg    = 1'b1;
        end else begin
          cmd_o.diff = 1'b1;
        end
      end
      S_MUL:  cmd_o.mul = 1'b1;
      S_DIV1: cmd_o.div1_start = 1'b1;
      S_DIV1_WAIT: begin
        if (sts_i.div_done) begin
          if (sts_i.uq_big) begin
            cmd_o.fin        = 1'b1;
            cmd_o.fin_status = ST_OK;
            cmd_o.fin_seg    = 1'b1;
          end else begin
            cmd_o.norm = 1'b1;
          end
        end
      end
      S_CHK_NORM: begin
        if (sts_i.ynorm_zero) begin
          cmd_o.fin        = 1'b1;
          cmd_o.fin_status = ST_ZDIV;
          cmd_o.fin_seg    = 1'b1;
        end else begin
          cmd_o.div2_start = 1'b1;
        end
      end
      S_DIV2_WAIT: begin
        if (sts_i.div_done) begin
          cmd_o.fin        = 1'b1;
          cmd_o.fin_status = ST_OK;
          cmd_o.fin_seg    = 1'b1;
          cmd_o.fin_ratio  = 1'b1;
        end
      end
      S_RESULT: cmd_o.emit = sts_i.out_free;
      default: cmd_o = '0;
    endcase
  end

endmodule

// ----- rtl/piecewise_linear_calibration_ratio.sv -----
// Top level of the piecewise linear calibration ratio block.
// Depends on plcr_pkg, plcr_ctrl and plcr_dp.
//
// Usage: one beat in on in_*, one beat out on out_* for every input beat.
// Opcode clear empties the table, load appends (x, y) or reports full,
// evaluate interpolates the table at x_value and returns y_value / y_norm
// in signed Q16.16 with the upper segment index.
// Clear and load go from dispatch straight to the result. Evaluate compares x
// with the first and last points, else scans the table for the segment, reads
// both of its points and, unless an error ends it early, runs the
// interpolation division and then the ratio division. The search walks the
// point memory one entry per cycle and both divisions share one radix-2 divider.
// Throughput: one beat at a time; in_ready_o is high only while idle.
// A finished beat waits in the result register while the receiver stalls;
// the next input is taken once it has moved to the output register.
// Reset clears the point count and the output valid; point memory contents
// are not cleared and are never read before being loaded.
module piecewise_linear_calibration_ratio #(
  parameter int unsigned TABLE_DEPTH = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  plcr_pkg::plcr_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output plcr_pkg::plcr_out_t out_data_o
);
  import plcr_pkg::*;

  plcr_cmd_t cmd;
  plcr_sts_t sts;

  plcr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  plcr_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .out_ready_i (out_ready_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule

// ----- rtl/plcr_checker.sv -----
// Port-level assertions for piecewise_linear_calibration_ratio, bound to the top.
// Depends on plcr_pkg for the status codes.
module plcr_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input plcr_pkg::plcr_in_t  in_data_i,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input plcr_pkg::plcr_out_t out_data_o
);
  import plcr_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output beat dropped or changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second beat taken while first is in flight");

  a_ratio_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.status == ST_OK) || (out_data_o.ratio == '0))
    else $error("nonzero ratio with error status");

  a_seg_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && ((out_data_o.status == ST_SHORT) || (out_data_o.status == ST_FULL))
    |-> out_data_o.segment_index == '0)
    else $error("segment index reported without a segment");

  a_opcode_seen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (in_data_i.opcode != OP_EVAL)
    |=> ##2 out_valid_o)
    else $error("clear or load beat not answered in three cycles");

endmodule

bind piecewise_linear_calibration_ratio plcr_checker u_plcr_checker (.*);

// ----- sim/ratio_checker.sv -----
// Scoreboard for the piecewise linear calibration ratio block: keeps its own calibration
// table, predicts one result per accepted input beat and checks each output beat in order.
// Depends on plcr_pkg for the beat types, opcodes and status codes.
`timescale 1ns / 1ps

module ratio_checker #(
  parameter int unsigned TABLE_DEPTH = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  plcr_pkg::plcr_in_t  in_data_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  plcr_pkg::plcr_out_t out_data_i,
  output int unsigned         mismatches_o,
  output int unsigned         pending_o
);
  import plcr_pkg::*;

  logic signed [DATA_W-1:0] cal_x [TABLE_DEPTH];
  logic signed [DATA_W-1:0] cal_y [TABLE_DEPTH];
  int unsigned              cal_count;
  plcr_out_t                expected_ratios [$];
  int unsigned              fail_count;

  function automatic plcr_out_t calibrate_beat(plcr_in_t beat);
    plcr_out_t         res;
    int unsigned       hi;
    int unsigned       last;
    longint            xq, ym, x0, x1, y0, y1, dx, dy, dq, q, ynorm, r;
    longint unsigned   mdx, mdy, mdq, prod, uq;
    bit                neg;
    res = '0;
    case (beat.opcode)
      OP_CLEAR: cal_count = 0;
      OP_LOAD: begin
        if (cal_count >= TABLE_DEPTH) begin
          res.status = ST_FULL;
        end else begin
          cal_x[cal_count] = beat.x_value;
          cal_y[cal_count] = beat.y_value;
          cal_count++;
        end
      end
      OP_EVAL: begin
        if (cal_count < 2) begin
          res.status = ST_SHORT;
          return res;
        end
        xq = $signed(beat.x_value);
        ym = $signed(beat.y_value);
        last = cal_count - 1;
        if (xq <= cal_x[0]) begin
          hi = 1;
        end else if (xq >= cal_x[last]) begin
          hi = last;
        end else begin
          hi = 1;
          while (hi < last && xq > cal_x[hi]) hi++;
        end
        res.segment_index = SEG_W'(hi);
        x0 = cal_x[hi-1];
        x1 = cal_x[hi];
        y0 = cal_y[hi-1];
        y1 = cal_y[hi];
        dx = x1 - x0;
        if (dx == 0) begin
          res.status = ST_ZDIV;
          return res;
        end
        dy = y1 - y0;
        dq = xq - x0;
        neg = ((dy < 0) != (dq < 0)) != (dx < 0);
        mdx = (dx < 0) ? -dx : dx;
        mdy = (dy < 0) ? -dy : dy;
        mdq = (dq < 0) ? -dq : dq;
        prod = mdy * mdq;
        uq = prod / mdx;
        if (uq >= 64'h4000_0000_0000_0000) return res;
        q = neg ? -longint'(uq) : longint'(uq);
        ynorm = y0 + q;
        if (ynorm == 0) begin
          res.status = ST_ZDIV;
          return res;
        end
        r = (ym * 65536) / ynorm;
        if (r > 64'sd2147483647) r = 64'sd2147483647;
        if (r < -64'sd2147483648) r = -64'sd2147483648;
        res.ratio = r[DATA_W-1:0];
      end
      default: ;
    endcase
    return res;
  endfunction

  always @(posedge clk_i) begin
    plcr_out_t want;
    if (!rst_ni) begin
      cal_count = 0;
      expected_ratios.delete();
      fail_count = 0;
    end else begin
      if (in_valid_i && in_ready_i) expected_ratios.push_back(calibrate_beat(in_data_i));
      if (out_valid_i && out_ready_i) begin
        if (expected_ratios.size() == 0) begin
          fail_count++;
          $display("%0t: expected no beat, got ratio %h status %0d segment %0d", $time,
                   out_data_i.ratio, out_data_i.status, out_data_i.segment_index);
        end else begin
          want = expected_ratios.pop_front();
          if (out_data_i.ratio !== want.ratio || out_data_i.status !== want.status ||
              out_data_i.segment_index !== want.segment_index) begin
            fail_count++;
            $display("%0t: expected ratio %h status %0d segment %0d, got %h %0d %0d",
                     $time, want.ratio, want.status, want.segment_index,
                     out_data_i.ratio, out_data_i.status, out_data_i.segment_index);
          end
        end
      end
    end
    mismatches_o <= fail_count;
    pending_o    <= expected_ratios.size();
  end

endmodule

// ----- sim/testbench.sv -----
// Top of the calibration ratio testbench: clock, reset, directed and random beats through
// four idle phases, receiver stalls, watchdog and verdict.
// Depends on plcr_pkg, piecewise_linear_calibration_ratio and ratio_checker.
`timescale 1ns / 1ps

module testbench;
  import plcr_pkg::*;

  localparam int unsigned TABLE_DEPTH     = 64;
  localparam int          CLK_PERIOD      = 8;
  localparam int          ITEMS_PER_PHASE = 275;
  localparam int          QUIET_LIMIT     = 20000;
  localparam int          DRAIN_CYCLES    = 250;

  typedef enum logic [2:0] {
    SEQ_WELL,
    SEQ_FILL,
    SEQ_UNSORTED,
    SEQ_SHORT,
    SEQ_NOISE
  } seq_kind_e;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  plcr_in_t    in_data;
  logic        out_valid;
  logic        out_ready;
  plcr_out_t   out_data;
  int unsigned mismatches;
  int unsigned pending;

  int          send_idle_pct;
  int          recv_stall_pct;
  int          beats_sent;
  int          quiet_cycles;

  always #(CLK_PERIOD / 2) clk = ~clk;

  piecewise_linear_calibration_ratio #(.TABLE_DEPTH(TABLE_DEPTH)) dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  ratio_checker #(.TABLE_DEPTH(TABLE_DEPTH)) u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_data_i   (out_data),
    .mismatches_o (mismatches),
    .pending_o    (pending)
  );

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  task automatic send_beat(input logic [1:0] op, input logic [31:0] xv, input logic [31:0] yv);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_data  <= {op, xv, yv};
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    beats_sent++;
  endtask

  task automatic run_sequence(input bit force_fill);
    seq_kind_e kind;
    int        pick;
    int        n;
    int        evals;
    int        xshift;
    int        yshift;
    int        i;
    int        j;
    int        key;
    int        qx;
    int        qy;
    int        xs [TABLE_DEPTH];
    int        ys [TABLE_DEPTH];
    pick = $urandom_range(99);
    if (force_fill) kind = SEQ_FILL;
    else if (pick < 56) kind = SEQ_WELL;
    else if (pick < 60) kind = SEQ_FILL;
    else if (pick < 74) kind = SEQ_UNSORTED;
    else if (pick < 85) kind = SEQ_SHORT;
    else kind = SEQ_NOISE;

    case (kind)
      SEQ_SHORT: begin
        send_beat(OP_CLEAR, $urandom, $urandom);
        if ($urandom_range(1)) send_beat(OP_LOAD, $urandom, $urandom);
        repeat ($urandom_range(1, 3)) send_beat(OP_EVAL, $urandom, $urandom);
      end
      SEQ_NOISE: begin
        repeat ($urandom_range(5, 15)) send_beat(2'($urandom_range(3)), $urandom, $urandom);
      end
      default: begin
        pick = $urandom_range(99);
        if (kind == SEQ_FILL) n = TABLE_DEPTH;
        else if (pick < 70) n = $urandom_range(2, 8);
        else if (pick < 95) n = $urandom_range(9, 24);
        else n = $urandom_range(25, TABLE_DEPTH);
        xshift = ($urandom_range(2) == 0) ? 0 : $urandom_range(8, 14);
        yshift = ($urandom_range(2) == 0) ? 0 : $urandom_range(8, 14);
        for (i = 0; i < n; i++) begin
          xs[i] = $signed($urandom) >>> xshift;
          ys[i] = ($urandom_range(19) == 0) ? 0 : $signed($urandom) >>> yshift;
          if (i > 0 && $urandom_range(9) == 0) xs[i] = xs[i-1];
        end
        if (kind != SEQ_UNSORTED) begin
          for (i = 1; i < n; i++) begin
            key = xs[i];
            j = i - 1;
            while (j >= 0 && xs[j] > key) begin
              xs[j+1] = xs[j];
              j--;
            end
            xs[j+1] = key;
          end
        end
        send_beat(OP_CLEAR, $urandom, $urandom);
        for (i = 0; i < n; i++) send_beat(OP_LOAD, xs[i], ys[i]);
        if (kind == SEQ_FILL) repeat ($urandom_range(1, 3)) send_beat(OP_LOAD, $urandom, $urandom);
        evals = $urandom_range(3, 10);
        repeat (evals) begin
          j = $urandom_range(n - 1);
          case ($urandom_range(5))
            0: qx = xs[j];
            1: qx = xs[j] + ($signed($urandom) >>> (xshift + 4));
            2: qx = xs[0] - $urandom_range(1000);
            3: qx = xs[n-1] + $urandom_range(1000);
            4: qx = $urandom;
            default: qx = (j < n - 1) ? int'((longint'(xs[j]) + xs[j+1]) / 2) : xs[j];
          endcase
          qy = ($urandom_range(7) == 0) ? ys[j] : $signed($urandom) >>> yshift;
          send_beat(OP_EVAL, qx, qy);
        end
      end
    endcase
  endtask

  initial begin
    int p;
    int phase_start;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_data        = '0;
    out_ready      = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    beats_sent     = 0;
    quiet_cycles   = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // empty and one-point tables
    send_beat(OP_EVAL, 32'h0000_0000, 32'h0001_0000);
    send_beat(OP_LOAD, 32'h0001_0000, 32'h0002_0000);
    send_beat(OP_EVAL, 32'h0001_0000, 32'h0002_0000);
    send_beat(OP_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    // extreme points, end segments and ratio saturation both ways
    send_beat(OP_CLEAR, 32'hFFFF_FFFF, 32'h0000_0000);
    send_beat(OP_LOAD, 32'h8000_0000, 32'h7FFF_FFFF);
    send_beat(OP_LOAD, 32'h7FFF_FFFF, 32'h8000_0000);
    send_beat(OP_EVAL, 32'h8000_0000, 32'h7FFF_FFFF);
    send_beat(OP_EVAL, 32'h7FFF_FFFF, 32'h8000_0000);
    send_beat(OP_EVAL, 32'h0000_0000, 32'h7FFF_FFFF);
    send_beat(OP_EVAL, 32'h0000_0000, 32'h8000_0000);
    // equal abscissas
    send_beat(OP_CLEAR, 32'h0000_0000, 32'h0000_0000);
    send_beat(OP_LOAD, 32'h0000_0000, 32'h0000_0000);
    send_beat(OP_LOAD, 32'h0000_0000, 32'h0005_0000);
    send_beat(OP_EVAL, 32'h0001_0000, 32'h0001_0000);
    // zero interpolated value, then a plain midpoint
    send_beat(OP_CLEAR, 32'h0000_0000, 32'h0000_0000);
    send_beat(OP_LOAD, 32'h0000_0000, 32'h0000_0000);
    send_beat(OP_LOAD, 32'h0001_0000, 32'h0001_0000);
    send_beat(OP_EVAL, 32'h0000_0000, 32'h0001_0000);
    send_beat(OP_EVAL, 32'h0000_8000, 32'h0001_0000);
    // interpolation term too large for the quotient
    send_beat(OP_CLEAR, 32'h0000_0000, 32'h0000_0000);
    send_beat(OP_LOAD, 32'h0000_0000, 32'h8000_0000);
    send_beat(OP_LOAD, 32'h0000_0001, 32'h7FFF_FFFF);
    send_beat(OP_EVAL, 32'h7FFF_FFFF, 32'h7FFF_FFFF);

    for (p = 0; p < 4; p++) begin
      case (p)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 84; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 84; end
        default: begin send_idle_pct = 9; recv_stall_pct = 9; end
      endcase
      phase_start = beats_sent;
      while (beats_sent - phase_start < ITEMS_PER_PHASE)
        run_sequence(p == 0 && beats_sent == phase_start);
    end
    in_valid <= 1'b0;
    recv_stall_pct = 0;

    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
